### rtl/core/vgu_pkg.sv
package vgu_pkg;

  // Component width of vectors and results
  localparam int VEC_W = 32;

  // Prescale target: largest magnitude lands in [2^SCALE_TOP, 2^(SCALE_TOP+1))
  localparam int SCALE_TOP = 29;

  // Square root iterations for a sum of three 60-bit squares (< 2^62)
  localparam int SQ_STEPS = 31;

  typedef enum logic [1:0] {
    OP_CROSS      = 2'd0,
    OP_UNIT_CROSS = 2'd1,
    OP_NORM       = 2'd2,
    OP_COS        = 2'd3
  } op_t;

  // Sideband that travels with each item down the pipeline
  typedef struct packed {
    op_t                   op;
    logic [2:0]            neg_a;    // signs of the vector being scaled
    logic [2:0]            neg_b;    // signs of B (cosine only)
    logic                  zero;     // divisor length was zero
    logic                  dot_neg;  // dot product sign (cosine only)
    logic [2:0][VEC_W-1:0] xr;       // rounded, clamped cross product
    logic                  sat;      // cross product clamp flag
  } meta_t;

  // Position of the highest set bit of a byte (0 when empty)
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

  // Clamp to signed 32 bits; msb of the result is the clamp flag
  function automatic logic [VEC_W:0] clamp32(input logic signed [64:0] v);
    logic [VEC_W:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### rtl/core/vector3_geometry_unit.sv
// Channel | Dir | Payload
// s_*     | in  | tdata: ax, ay, az, bx, by, bz (32 b each); tuser: req_type
// m_*     | out | tdata: rx, ry, rz (32 b each); tuser: zero_length, saturated
//
// Fully pipelined: one transfer per cycle in and out while the output is not stalled.
// FRAC_BITS + 46 register stages, among them the 31-step square root pipeline
// and the FRAC_BITS + 3 step restoring divider.
// rst is synchronous and clears only the valid bits.
// All stages advance together whenever the output register is empty or taken;
// a stall freezes every stage, nothing is lost or repeated.
module vector3_geometry_unit
  import vgu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // ax, ay, az, bx, by, bz from bit 0 up
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // rx, ry, rz from bit 0 up
  output logic [1:0]   m_tuser    // zero_length, saturated from bit 0 up
);

  localparam int QW    = FRAC_BITS + 3;          // divider quotient bits
  localparam int SQ0   = 10;                     // first sqrt stage index
  localparam int DN    = SQ0 + SQ_STEPS;         // divider setup stage
  localparam int NV    = DN + QW + 2;            // total register stages
  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  logic          adv;
  logic [NV-1:0] vld;

  // Global advance: output register free or being taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], s_tvalid};
    end
  end

  // Stage 0: input capture
  op_t                op0;
  logic signed [31:0] a0 [3];
  logic signed [31:0] b0 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= op_t'(s_tuser);
      for (int i = 0; i < 3; i++) begin
        a0[i] <= s_tdata[32*i +: 32];
        b0[i] <= s_tdata[96+32*i +: 32];
      end
    end
  end

  // Stage 1: cross product partial products
  op_t                op1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [63:0] p1 [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= op0;
      a1    <= a0;
      b1    <= b0;
      p1[0] <= a0[1] * b0[2];
      p1[1] <= a0[2] * b0[1];
      p1[2] <= a0[2] * b0[0];
      p1[3] <= a0[0] * b0[2];
      p1[4] <= a0[0] * b0[1];
      p1[5] <= a0[1] * b0[0];
    end
  end

  // Stage 2: cross product components at 2*FRAC_BITS fraction bits
  op_t                op2;
  logic signed [31:0] a2 [3];
  logic signed [31:0] b2 [3];
  logic signed [64:0] c2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      op2   <= op1;
      a2    <= a1;
      b2    <= b1;
      c2[0] <= p1[0] - p1[1];
      c2[1] <= p1[2] - p1[3];
      c2[2] <= p1[4] - p1[5];
    end
  end

  // Stage 3: round cross product; magnitudes and signs for scaling
  meta_t       meta3, meta3_next;
  logic [63:0] ma3 [3];
  logic [63:0] mb3 [3];
  logic [63:0] ma3_next [3];
  logic [63:0] mb3_next [3];

  always_comb begin
    logic signed [64:0] rnd;
    logic signed [64:0] cm;
    logic signed [64:0] ae;
    logic signed [64:0] be;
    logic [32:0]        cl;
    meta3_next       = '0;
    meta3_next.op    = op2;
    for (int i = 0; i < 3; i++) begin
      rnd = (c2[i] + HALF) >>> FRAC_BITS;
      cl  = clamp32(rnd);
      meta3_next.xr[i] = cl[31:0];
      if (cl[32]) meta3_next.sat = 1'b1;
      cm = c2[i][64] ? -c2[i] : c2[i];
      ae = 65'(a2[i]);
      be = 65'(b2[i]);
      if (ae < 0) ae = -ae;
      if (be < 0) be = -be;
      if (op2 == OP_UNIT_CROSS) begin
        ma3_next[i]         = cm[63:0];
        meta3_next.neg_a[i] = c2[i][64];
      end else begin
        ma3_next[i]         = ae[63:0];
        meta3_next.neg_a[i] = a2[i][31];
      end
      mb3_next[i]         = be[63:0];
      meta3_next.neg_b[i] = b2[i][31];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta3 <= meta3_next;
      ma3   <= ma3_next;
      mb3   <= mb3_next;
    end
  end

  // Stage 4: largest magnitude per vector; zero vector detect
  meta_t       meta4, meta4_next;
  logic [63:0] ma4 [3];
  logic [63:0] mb4 [3];
  logic [63:0] mxa4, mxb4;
  logic [63:0] mxa01, mxb01;
  logic        za3, zb3;

  assign mxa01 = (ma3[0] > ma3[1]) ? ma3[0] : ma3[1];
  assign mxb01 = (mb3[0] > mb3[1]) ? mb3[0] : mb3[1];
  assign za3   = (ma3[0] | ma3[1] | ma3[2]) == '0;
  assign zb3   = (mb3[0] | mb3[1] | mb3[2]) == '0;

  always_comb begin
    meta4_next = meta3;
    case (meta3.op)
      OP_CROSS:      meta4_next.zero = 1'b0;
      OP_UNIT_CROSS: meta4_next.zero = za3;
      OP_NORM:       meta4_next.zero = za3;
      OP_COS:        meta4_next.zero = za3 || zb3;
      default:       meta4_next.zero = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta4 <= meta4_next;
      ma4  <= ma3;
      mb4  <= mb3;
      mxa4 <= (mxa01 > ma3[2]) ? mxa01 : ma3[2];
      mxb4 <= (mxb01 > mb3[2]) ? mxb01 : mb3[2];
    end
  end

  // Stage 5: leading one search, per byte
  meta_t           meta5;
  logic [63:0]     ma5 [3];
  logic [63:0]     mb5 [3];
  logic [7:0]      nza5, nzb5;
  logic [7:0][2:0] posa5, posb5;

  always_ff @(posedge clk) begin
    if (adv) begin
      meta5 <= meta4;
      ma5   <= ma4;
      mb5   <= mb4;
      for (int g = 0; g < 8; g++) begin
        nza5[g]  <= |mxa4[8*g +: 8];
        nzb5[g]  <= |mxb4[8*g +: 8];
        posa5[g] <= msb8(mxa4[8*g +: 8]);
        posb5[g] <= msb8(mxb4[8*g +: 8]);
      end
    end
  end

  // Stage 6: leading one search, byte select
  meta_t       meta6;
  logic [63:0] ma6 [3];
  logic [63:0] mb6 [3];
  logic [5:0]  pa6, pb6;
  logic [2:0]  ga5, gb5;

  assign ga5 = msb8(nza5);
  assign gb5 = msb8(nzb5);

  always_ff @(posedge clk) begin
    if (adv) begin
      meta6 <= meta5;
      ma6   <= ma5;
      mb6   <= mb5;
      pa6   <= {ga5, posa5[ga5]};
      pb6   <= {gb5, posb5[gb5]};
    end
  end

  // Stage 7: prescale shift, largest magnitude into [2^29, 2^30)
  meta_t       meta7;
  logic [29:0] sa7 [3];
  logic [29:0] sb7 [3];
  logic [63:0] sa7_next [3];
  logic [63:0] sb7_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pa6 > 6'(SCALE_TOP)) sa7_next[i] = ma6[i] >> (pa6 - 6'(SCALE_TOP));
      else                     sa7_next[i] = ma6[i] << (6'(SCALE_TOP) - pa6);
      if (pb6 > 6'(SCALE_TOP)) sb7_next[i] = mb6[i] >> (pb6 - 6'(SCALE_TOP));
      else                     sb7_next[i] = mb6[i] << (6'(SCALE_TOP) - pb6);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta7 <= meta6;
      for (int i = 0; i < 3; i++) begin
        sa7[i] <= sa7_next[i][29:0];
        sb7[i] <= sb7_next[i][29:0];
      end
    end
  end

  // Stage 8: squares and dot product terms
  meta_t       meta8;
  logic [29:0] sa8 [3];
  logic [59:0] qa8 [3];
  logic [59:0] qb8 [3];
  logic [59:0] pr8 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      meta8 <= meta7;
      sa8   <= sa7;
      for (int i = 0; i < 3; i++) begin
        qa8[i] <= sa7[i] * sa7[i];
        qb8[i] <= sb7[i] * sb7[i];
        pr8[i] <= sa7[i] * sb7[i];
      end
    end
  end

  // Stage 9: sums of squares and signed dot product
  meta_t              meta9;
  logic [29:0]        sa9 [3];
  logic [61:0]        suma9, sumb9;
  logic signed [63:0] dot9, dot9_next;

  always_comb begin
    logic signed [63:0] t;
    dot9_next = '0;
    for (int i = 0; i < 3; i++) begin
      t = $signed(64'(pr8[i]));
      if (meta8.neg_a[i] ^ meta8.neg_b[i]) t = -t;
      dot9_next = dot9_next + t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta9 <= meta8;
      sa9   <= sa8;
      suma9 <= 62'(qa8[0]) + 62'(qa8[1]) + 62'(qa8[2]);
      sumb9 <= 62'(qb8[0]) + 62'(qb8[1]) + 62'(qb8[2]);
      dot9  <= dot9_next;
    end
  end

  // Square root pipeline, one result bit per stage, both vectors
  logic [63:0]        sq_rem_a [SQ_STEPS];
  logic [63:0]        sq_res_a [SQ_STEPS];
  logic [63:0]        sq_rem_b [SQ_STEPS];
  logic [63:0]        sq_res_b [SQ_STEPS];
  logic signed [63:0] sq_dot   [SQ_STEPS];
  logic [2:0][29:0]   sq_sa    [SQ_STEPS];
  meta_t              sq_meta  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (60 - 2 * k);
    logic [63:0]        ia_rem, ia_res, ib_rem, ib_res;
    logic [63:0]        ta, tb;
    logic signed [63:0] i_dot;
    logic [2:0][29:0]   i_sa;
    meta_t              i_meta;

    if (k == 0) begin : g_first
      assign ia_rem = 64'(suma9);
      assign ib_rem = 64'(sumb9);
      assign ia_res = '0;
      assign ib_res = '0;
      assign i_dot  = dot9;
      assign i_sa   = {sa9[2], sa9[1], sa9[0]};
      assign i_meta = meta9;
    end else begin : g_next
      assign ia_rem = sq_rem_a[k-1];
      assign ib_rem = sq_rem_b[k-1];
      assign ia_res = sq_res_a[k-1];
      assign ib_res = sq_res_b[k-1];
      assign i_dot  = sq_dot[k-1];
      assign i_sa   = sq_sa[k-1];
      assign i_meta = sq_meta[k-1];
    end

    assign ta = ia_res + BIT;
    assign tb = ib_res + BIT;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_dot[k]  <= i_dot;
        sq_sa[k]   <= i_sa;
        sq_meta[k] <= i_meta;
        if (ia_rem >= ta) begin
          sq_rem_a[k] <= ia_rem - ta;
          sq_res_a[k] <= (ia_res >> 1) + BIT;
        end else begin
          sq_rem_a[k] <= ia_rem;
          sq_res_a[k] <= ia_res >> 1;
        end
        if (ib_rem >= tb) begin
          sq_rem_b[k] <= ib_rem - tb;
          sq_res_b[k] <= (ib_res >> 1) + BIT;
        end else begin
          sq_rem_b[k] <= ib_rem;
          sq_res_b[k] <= ib_res >> 1;
        end
      end
    end
  end

  // Divider setup: lane 0 carries the cosine, all lanes the unit vector
  logic [30:0]        len_a, len_b;
  logic [61:0]        len_ab;
  logic signed [63:0] dot_s;
  logic [63:0]        dot_abs;
  logic [63:0]        dn_rem [3];
  logic [62:0]        dn_d   [3];
  logic [63:0]        dn_rem_next [3];
  logic [62:0]        dn_d_next   [3];
  meta_t              dn_meta, dn_meta_next;

  assign len_a   = sq_res_a[SQ_STEPS-1][30:0];
  assign len_b   = sq_res_b[SQ_STEPS-1][30:0];
  assign len_ab  = len_a * len_b;
  assign dot_s   = sq_dot[SQ_STEPS-1];
  assign dot_abs = dot_s[63] ? 64'(-dot_s) : 64'(dot_s);

  always_comb begin
    dn_meta_next         = sq_meta[SQ_STEPS-1];
    dn_meta_next.dot_neg = dot_s[63];
    for (int j = 0; j < 3; j++) begin
      dn_rem_next[j] = 64'(sq_sa[SQ_STEPS-1][j]);
      dn_d_next[j]   = 63'(len_a);
    end
    if (sq_meta[SQ_STEPS-1].op == OP_COS) begin
      dn_rem_next[0] = dot_abs;
      dn_d_next[0]   = 63'(len_ab);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_meta <= dn_meta_next;
      dn_rem  <= dn_rem_next;
      dn_d    <= dn_d_next;
    end
  end

  // Restoring divider: two integer bits, then FRAC_BITS + 1 fraction bits
  logic [63:0]   dv_rem  [QW][3];
  logic [62:0]   dv_d    [QW][3];
  logic [QW-1:0] dv_q    [QW][3];
  meta_t         dv_meta [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    meta_t i_meta;

    if (k == 0) begin : g_meta_first
      assign i_meta = dn_meta;
    end else begin : g_meta_next
      assign i_meta = dv_meta[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) dv_meta[k] <= i_meta;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [63:0]   i_rem;
      logic [62:0]   i_d;
      logic [QW-1:0] i_q;
      logic [64:0]   t, dd;
      logic          ge;

      if (k == 0) begin : g_first
        assign i_rem = dn_rem[j];
        assign i_d   = dn_d[j];
        assign i_q   = '0;
        assign t     = {1'b0, i_rem};
        assign dd    = {1'b0, i_d, 1'b0};
      end else if (k == 1) begin : g_second
        assign i_rem = dv_rem[k-1][j];
        assign i_d   = dv_d[k-1][j];
        assign i_q   = dv_q[k-1][j];
        assign t     = {1'b0, i_rem};
        assign dd    = {2'b0, i_d};
      end else begin : g_frac
        assign i_rem = dv_rem[k-1][j];
        assign i_d   = dv_d[k-1][j];
        assign i_q   = dv_q[k-1][j];
        assign t     = {i_rem, 1'b0};
        assign dd    = {2'b0, i_d};
      end

      assign ge = t >= dd;

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_d[k][j]   <= i_d;
          dv_q[k][j]   <= {i_q[QW-2:0], ge};
          dv_rem[k][j] <= ge ? 64'(t - dd) : t[63:0];
        end
      end
    end
  end

  // Output stage: round quotient, apply sign, select by operation
  meta_t       om;
  logic [32:0] lane_cl [3];
  logic [31:0] rx_next, ry_next, rz_next;
  logic        zl_next, sat_next;
  op_t         out_op;

  assign om = dv_meta[QW-1];

  always_comb begin
    logic [QW:0]        qr;
    logic signed [64:0] sv;
    logic               neg;
    for (int j = 0; j < 3; j++) begin
      qr  = ({1'b0, dv_q[QW-1][j]} + {{QW{1'b0}}, 1'b1}) >> 1;
      neg = om.neg_a[j];
      if (j == 0 && om.op == OP_COS) neg = om.dot_neg;
      sv  = $signed(65'(qr));
      if (neg) sv = -sv;
      lane_cl[j] = clamp32(sv);
    end
  end

  always_comb begin
    rx_next  = '0;
    ry_next  = '0;
    rz_next  = '0;
    zl_next  = om.zero;
    sat_next = 1'b0;
    case (om.op)
      OP_CROSS: begin
        rx_next  = om.xr[0];
        ry_next  = om.xr[1];
        rz_next  = om.xr[2];
        sat_next = om.sat;
        zl_next  = 1'b0;
      end
      OP_UNIT_CROSS, OP_NORM: begin
        if (!om.zero) begin
          rx_next  = lane_cl[0][31:0];
          ry_next  = lane_cl[1][31:0];
          rz_next  = lane_cl[2][31:0];
          sat_next = lane_cl[0][32] || lane_cl[1][32] || lane_cl[2][32];
        end
      end
      OP_COS: begin
        if (!om.zero) begin
          rx_next  = lane_cl[0][31:0];
          sat_next = lane_cl[0][32];
        end
      end
      default: begin
        zl_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {rz_next, ry_next, rx_next};
      m_tuser <= {sat_next, zl_next};
      out_op  <= om.op;
    end
  end

  // A zero length always comes with an all-zero result, never from a cross
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && out_op != OP_CROSS)
    else $error("zero_length with nonzero result");

  // Only the plain cross product can clamp
  a_sat_cross: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> out_op == OP_CROSS)
    else $error("saturation outside cross product");

  // Cosine leaves y and z at zero
  a_cos_yz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_op == OP_COS |-> m_tdata[95:32] == '0)
    else $error("cosine with nonzero y or z");

endmodule
